>>> rtl/core/lcd_line_timing_status_macros.svh
// Assertion helpers for the LCD line timing block.
`ifndef LCD_LINE_TIMING_STATUS_MACROS_SVH
`define LCD_LINE_TIMING_STATUS_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcd timing check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define LTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcd timing check failed");

`endif

>>> rtl/core/lcd_lts_pkg.sv
package lcd_lts_pkg;

  localparam int CNT_W  = 10;
  localparam int LINE_W = 8;
  localparam int TICK_W = 8;
  localparam int SUM_W  = CNT_W + 1;

  localparam logic [SUM_W-1:0]  LINE_CYCLES  = SUM_W'(456);
  localparam logic [CNT_W-1:0]  OAM_SCAN_END = CNT_W'(80);
  localparam logic [CNT_W-1:0]  TRANSFER_END = CNT_W'(252);
  localparam logic [LINE_W-1:0] LAST_LINE    = LINE_W'(153);
  localparam logic [LINE_W-1:0] VBLANK_LINE  = LINE_W'(144);

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } lcd_mode_t;

  typedef struct packed {
    logic [TICK_W-1:0] ticks;
    logic              lcd_enable;
    logic [LINE_W-1:0] line_compare;
    logic              hblank_irq_enable;
    logic              vblank_irq_enable;
    logic              oam_irq_enable;
    logic              match_irq_enable;
  } lts_in_t;

  typedef struct packed {
    logic [CNT_W-1:0]  dot_counter;
    logic [LINE_W-1:0] current_line;
    lcd_mode_t         current_mode;
    logic              match_flag;
  } lts_state_t;

  typedef struct packed {
    lcd_mode_t         mode;
    logic [LINE_W-1:0] line_number;
    logic              coincidence;
    logic              stat_irq;
    logic              vblank_irq;
    logic              render_request;
    logic [LINE_W-1:0] render_line;
  } lts_out_t;

endpackage

>>> rtl/core/lcd_lts_ifs.sv
interface lcd_lts_in_if import lcd_lts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] ticks;
  logic              lcd_enable;
  logic [LINE_W-1:0] line_compare;
  logic              hblank_irq_enable;
  logic              vblank_irq_enable;
  logic              oam_irq_enable;
  logic              match_irq_enable;

  modport source (
    output valid, ticks, lcd_enable, line_compare, hblank_irq_enable,
           vblank_irq_enable, oam_irq_enable, match_irq_enable,
    input  ready
  );
  modport sink (
    input  valid, ticks, lcd_enable, line_compare, hblank_irq_enable,
           vblank_irq_enable, oam_irq_enable, match_irq_enable,
    output ready
  );
endinterface

interface lcd_lts_out_if import lcd_lts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [LINE_W-1:0] line_number;
  logic              coincidence;
  logic              stat_irq;
  logic              vblank_irq;
  logic              render_request;
  logic [LINE_W-1:0] render_line;

  modport source (
    output valid, mode, line_number, coincidence, stat_irq, vblank_irq,
           render_request, render_line,
    input  ready
  );
  modport sink (
    input  valid, mode, line_number, coincidence, stat_irq, vblank_irq,
           render_request, render_line,
    output ready
  );
endinterface

>>> rtl/core/lcd_line_timing_status.sv
// Path: an accepted input word passes through the input register, then the
//   result register, which holds its result word.
// Throughput: one word per cycle while dout.ready holds; the line state
//   updates as the result register loads, so words chain without a bubble.
// Reset (rst, synchronous, active high): both stages empty, dot counter,
//   line, mode and coincidence flag cleared to zero.
`include "lcd_line_timing_status_macros.svh"

module lcd_line_timing_status import lcd_lts_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  lcd_lts_in_if.sink    din,
  lcd_lts_out_if.source dout
);

  // Input stage: holds one tick report until the state update takes it.
  logic       in_vld;
  lts_in_t    in_word;

  // Timing state carried from word to word.
  lts_state_t st;
  lts_state_t st_next;

  // Result stage.
  logic       out_vld;
  lts_out_t   out_word;
  lts_out_t   res;

  logic       adv;
  logic       take;

  // A word moves from the input stage into the result register whenever the
  // result register is empty or is being drained this cycle. The state moves
  // along with it, so the next word sees the updated counter and line.
  assign adv       = in_vld && (!out_vld || dout.ready);
  assign din.ready = !in_vld || adv;
  assign take      = din.valid && din.ready;

  lcd_lts_step u_step (
    .word    (in_word),
    .st      (st),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (din.ready) begin
      in_vld <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_word.ticks             <= din.ticks;
      in_word.lcd_enable        <= din.lcd_enable;
      in_word.line_compare      <= din.line_compare;
      in_word.hblank_irq_enable <= din.hblank_irq_enable;
      in_word.vblank_irq_enable <= din.vblank_irq_enable;
      in_word.oam_irq_enable    <= din.oam_irq_enable;
      in_word.match_irq_enable  <= din.match_irq_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (adv) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= 1'b1;
    end else if (dout.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word <= res;
    end
  end

  assign dout.valid          = out_vld;
  assign dout.mode           = out_word.mode;
  assign dout.line_number    = out_word.line_number;
  assign dout.coincidence    = out_word.coincidence;
  assign dout.stat_irq       = out_word.stat_irq;
  assign dout.vblank_irq     = out_word.vblank_irq;
  assign dout.render_request = out_word.render_request;
  assign dout.render_line    = out_word.render_line;

  // Counter wraps once per line, so it never reaches a full line.
  `LTS_ASSERT_NOW(a_cnt_range, 1'b1, st.dot_counter < LINE_CYCLES)
  // Line number wraps after the last vblank line.
  `LTS_ASSERT_NOW(a_line_range, 1'b1, st.current_line <= LAST_LINE)
  // A render request only comes with the entry into hblank.
  `LTS_ASSERT_NOW(a_render_mode, out_vld && out_word.render_request,
                  out_word.mode == MODE_HBLANK)
  // The vblank pulse marks the first vblank line.
  `LTS_ASSERT_NOW(a_vblank_line, out_vld && out_word.vblank_irq,
                  out_word.line_number == VBLANK_LINE)
  // Every word that leaves the input stage shows up as a result.
  `LTS_ASSERT_NEXT(a_adv_result, adv, out_vld)

endmodule

>>> rtl/core/lcd_lts_step.sv
// Next-state and result logic for one tick report.
module lcd_lts_step import lcd_lts_pkg::*; (
  input  lts_in_t    word,
  input  lts_state_t st,
  output lts_state_t st_next,
  output lts_out_t   res
);

  logic [CNT_W-1:0]  base_cnt;
  logic [LINE_W-1:0] base_line;
  logic              base_match;
  logic              want;
  logic [SUM_W-1:0]  sum;
  logic              wrap;
  logic [LINE_W-1:0] line_inc;
  logic [LINE_W-1:0] new_line;
  logic              hit;

  always_comb begin
    res            = '0;
    want           = 1'b0;
    base_cnt       = st.dot_counter;
    base_line      = st.current_line;
    base_match     = st.match_flag;
    st_next        = st;

    // Mode from the counter and line held before this word.
    if (!word.lcd_enable) begin
      res.mode   = MODE_VBLANK;
      base_cnt   = '0;
      base_line  = '0;
      base_match = 1'b0;
    end else if (st.current_line >= VBLANK_LINE) begin
      res.mode = MODE_VBLANK;
      want     = word.vblank_irq_enable;
    end else if (st.dot_counter < OAM_SCAN_END) begin
      res.mode = MODE_OAM;
      want     = word.oam_irq_enable;
    end else if (st.dot_counter < TRANSFER_END) begin
      res.mode = MODE_XFER;
    end else begin
      res.mode = MODE_HBLANK;
      want     = word.hblank_irq_enable;
      if (st.current_mode == MODE_XFER) begin
        res.render_request = 1'b1;
        res.render_line    = st.current_line;
      end
    end
    res.stat_irq = want && (res.mode != st.current_mode);

    // Advance the dot counter; a full line steps the line number.
    sum      = {1'b0, base_cnt} + SUM_W'(word.ticks);
    wrap     = sum >= LINE_CYCLES;
    line_inc = base_line + LINE_W'(1);
    new_line = (line_inc > LAST_LINE) ? '0 : line_inc;
    hit      = word.line_compare == new_line;

    if (wrap) begin
      st_next.dot_counter  = CNT_W'(sum - LINE_CYCLES);
      st_next.current_line = new_line;
      st_next.match_flag   = hit;
      res.stat_irq         = res.stat_irq || (hit && word.match_irq_enable);
      res.vblank_irq       = new_line == VBLANK_LINE;
    end else begin
      st_next.dot_counter  = sum[CNT_W-1:0];
      st_next.current_line = base_line;
      st_next.match_flag   = base_match;
    end
    st_next.current_mode = res.mode;

    res.line_number = st_next.current_line;
    res.coincidence = st_next.match_flag;
  end

endmodule

>>> tb/sv/lts_status_checker.sv
`timescale 1ns / 100ps

module lts_status_checker import lcd_lts_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  lcd_lts_in_if  step_mon,
  lcd_lts_out_if status_mon,
  output int     fails,
  output int     pending
);

  lts_state_t tstate;
  lts_out_t   status_q[$];

  initial begin
    fails   = 0;
    pending = 0;
  end

  // Mode choice uses the counter and line from before this word's ticks.
  function automatic lts_out_t timing_step(lts_in_t w);
    lts_out_t         r;
    lcd_mode_t        prev;
    logic             want;
    logic [SUM_W-1:0] sum;
    logic [LINE_W-1:0] nxt;
    r    = '0;
    want = 1'b0;
    if (!w.lcd_enable) begin
      tstate.current_mode = MODE_VBLANK;
      tstate.match_flag   = 1'b0;
      tstate.current_line = '0;
      tstate.dot_counter  = '0;
    end else begin
      prev = tstate.current_mode;
      if (tstate.current_line >= VBLANK_LINE) begin
        tstate.current_mode = MODE_VBLANK;
        want = w.vblank_irq_enable;
      end else if (tstate.dot_counter < OAM_SCAN_END) begin
        tstate.current_mode = MODE_OAM;
        want = w.oam_irq_enable;
      end else if (tstate.dot_counter < TRANSFER_END) begin
        tstate.current_mode = MODE_XFER;
      end else begin
        if (prev == MODE_XFER) begin
          r.render_request = 1'b1;
          r.render_line    = tstate.current_line;
        end
        tstate.current_mode = MODE_HBLANK;
        want = w.hblank_irq_enable;
      end
      r.stat_irq = want && (tstate.current_mode != prev);
    end
    // ticks still count while the display is off
    sum = SUM_W'(tstate.dot_counter) + SUM_W'(w.ticks);
    if (sum >= LINE_CYCLES) begin
      sum = sum - LINE_CYCLES;
      nxt = tstate.current_line + 1'b1;
      if (nxt > LAST_LINE) nxt = '0;
      tstate.current_line = nxt;
      if (w.line_compare == nxt) begin
        tstate.match_flag = 1'b1;
        if (w.match_irq_enable) r.stat_irq = 1'b1;
      end else begin
        tstate.match_flag = 1'b0;
      end
      r.vblank_irq = (nxt == VBLANK_LINE);
    end
    tstate.dot_counter = sum[CNT_W-1:0];
    r.mode        = tstate.current_mode;
    r.line_number = tstate.current_line;
    r.coincidence = tstate.match_flag;
    return r;
  endfunction

  function automatic int field_bad(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (exp_v === got_v) return 0;
    $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
    return 1;
  endfunction

  always @(posedge clk) begin : monitor
    lts_in_t  w;
    lts_out_t got;
    lts_out_t exp_w;
    int       bad;
    if (rst) begin
      tstate = '0;
      status_q.delete();
    end else begin
      // results first: a word accepted at this edge cannot have its result yet
      if (status_mon.valid && status_mon.ready) begin
        got.mode           = lcd_mode_t'(status_mon.mode);
        got.line_number    = status_mon.line_number;
        got.coincidence    = status_mon.coincidence;
        got.stat_irq       = status_mon.stat_irq;
        got.vblank_irq     = status_mon.vblank_irq;
        got.render_request = status_mon.render_request;
        got.render_line    = status_mon.render_line;
        if (status_q.size() == 0) begin
          $display("%0t: unexpected status word, mode %0d line %0d", $time,
                   got.mode, got.line_number);
          fails++;
        end else begin
          exp_w = status_q.pop_front();
          bad = 0;
          bad += field_bad("mode", 8'(exp_w.mode), 8'(got.mode));
          bad += field_bad("line_number", exp_w.line_number, got.line_number);
          bad += field_bad("coincidence", 8'(exp_w.coincidence), 8'(got.coincidence));
          bad += field_bad("stat_irq", 8'(exp_w.stat_irq), 8'(got.stat_irq));
          bad += field_bad("vblank_irq", 8'(exp_w.vblank_irq), 8'(got.vblank_irq));
          bad += field_bad("render_request", 8'(exp_w.render_request),
                           8'(got.render_request));
          bad += field_bad("render_line", exp_w.render_line, got.render_line);
          if (bad != 0) fails++;
        end
      end
      if (step_mon.valid && step_mon.ready) begin
        w.ticks             = step_mon.ticks;
        w.lcd_enable        = step_mon.lcd_enable;
        w.line_compare      = step_mon.line_compare;
        w.hblank_irq_enable = step_mon.hblank_irq_enable;
        w.vblank_irq_enable = step_mon.vblank_irq_enable;
        w.oam_irq_enable    = step_mon.oam_irq_enable;
        w.match_irq_enable  = step_mon.match_irq_enable;
        status_q.push_back(timing_step(w));
      end
    end
    pending = status_q.size();
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import lcd_lts_pkg::*;

  // idle cycles with no word moving on either side before we give up
  localparam int IDLE_LIMIT   = 3000;
  localparam int RANDOM_WORDS = 1300;

  logic clk = 1'b0;
  logic rst;
  int   fails;
  int   pending;
  int   idle_cycles;

  lcd_lts_in_if  step_bus ();
  lcd_lts_out_if status_bus ();

  always #1 clk = ~clk;

  lcd_line_timing_status i_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (step_bus),
    .dout (status_bus)
  );

  lts_status_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .step_mon   (step_bus),
    .status_mon (status_bus),
    .fails      (fails),
    .pending    (pending)
  );

  // irq bits are {hblank, vblank, oam, match}
  function automatic lts_in_t pack_step(int ticks, bit en, int cmp, bit [3:0] irq);
    lts_in_t w;
    w.ticks             = TICK_W'(ticks);
    w.lcd_enable        = en;
    w.line_compare      = LINE_W'(cmp);
    w.hblank_irq_enable = irq[3];
    w.vblank_irq_enable = irq[2];
    w.oam_irq_enable    = irq[1];
    w.match_irq_enable  = irq[0];
    return w;
  endfunction

  task automatic drive_step(lts_in_t w);
    step_bus.ticks             <= w.ticks;
    step_bus.lcd_enable        <= w.lcd_enable;
    step_bus.line_compare      <= w.line_compare;
    step_bus.hblank_irq_enable <= w.hblank_irq_enable;
    step_bus.vblank_irq_enable <= w.vblank_irq_enable;
    step_bus.oam_irq_enable    <= w.oam_irq_enable;
    step_bus.match_irq_enable  <= w.match_irq_enable;
  endtask

  initial begin : stimulus
    lts_in_t  step_q[$];
    lts_in_t  w;
    int       burst;
    int       gap;
    int       seg_len;
    int       seg_cmp;
    int       style;
    int       off_odds;
    int       ticks_v;
    int       cmp_v;
    bit [3:0] seg_irq;
    bit [3:0] irq_v;
    bit       en_v;

    rst <= 1'b1;
    step_bus.valid <= 1'b0;
    drive_step('0);

    // Directed walk from reset: every mode, a render request, an hblank
    // entry straight from oam scan (no render), a line match with and
    // without its irq, display off (ticks still counted) and back on
    // mid-line, and ticks/compare at both extremes.
    step_q.push_back(pack_step(0,   1, 0,   4'b1111)); // oam entry, irq
    step_q.push_back(pack_step(80,  1, 0,   4'b1111)); // counter to oam end
    step_q.push_back(pack_step(171, 1, 0,   4'b1111)); // transfer
    step_q.push_back(pack_step(1,   1, 0,   4'b1111)); // last transfer dot
    step_q.push_back(pack_step(204, 1, 1,   4'b1111)); // hblank + render, wrap, match irq
    step_q.push_back(pack_step(255, 1, 255, 4'b0000)); // oam, enables off
    step_q.push_back(pack_step(255, 1, 255, 4'b0000)); // oam -> hblank, no render
    step_q.push_back(pack_step(0,   0, 170, 4'b1111)); // display off, no irq
    step_q.push_back(pack_step(255, 0, 85,  4'b1111)); // off, ticks still added
    step_q.push_back(pack_step(0,   1, 0,   4'b0110)); // on mid-line: hblank
    step_q.push_back(pack_step(201, 1, 1,   4'b1001)); // wrap exactly, match irq
    step_q.push_back(pack_step(100, 1, 128, 4'b0010)); // oam irq
    step_q.push_back(pack_step(0,   1, 128, 4'b0010)); // transfer
    step_q.push_back(pack_step(152, 1, 128, 4'b1110)); // to transfer end
    step_q.push_back(pack_step(0,   1, 128, 4'b0110)); // render line 1, irq off
    step_q.push_back(pack_step(255, 1, 2,   4'b0000)); // match flag, no irq
    step_q.push_back(pack_step(128, 1, 2,   4'b0010)); // oam irq
    step_q.push_back(pack_step(255, 1, 153, 4'b1111));

    // Random part in segments. The first one runs fast ticks with the
    // display on long enough to pass vblank and the 153 -> 0 wrap.
    // Later segments mix tick sizes; a few toggle the display off often.
    for (int seg = 0; step_q.size() < RANDOM_WORDS + 18; seg++) begin
      seg_len  = $urandom_range(20, 300);
      style    = $urandom_range(0, 5);
      off_odds = ($urandom_range(0, 5) == 0) ? 16 : 0;
      seg_cmp  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) :
                                               $urandom_range(0, 153);
      seg_irq  = 4'($urandom_range(0, 15));
      if (seg == 0) begin
        seg_len  = 450;
        style    = 2;
        off_odds = 0;
      end
      if (style == 4) seg_len = $urandom_range(10, 60);
      for (int i = 0; i < seg_len && step_q.size() < RANDOM_WORDS + 18; i++) begin
        if (style <= 1)      ticks_v = $urandom_range(0, 255);
        else if (style <= 3) ticks_v = $urandom_range(192, 255);
        else if (style == 4) ticks_v = $urandom_range(0, 12);  // walk each mode finely
        else                 ticks_v = $urandom_range(40, 120);
        en_v  = (off_odds == 0) || ($urandom_range(0, off_odds - 1) != 0);
        cmp_v = ($urandom_range(0, 3) != 0) ? seg_cmp : $urandom_range(0, 255);
        irq_v = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : seg_irq;
        step_q.push_back(pack_step(ticks_v, en_v, cmp_v, irq_v));
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // bursts of words with random gaps; valid stays up through stalls
    while (step_q.size() != 0) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 24);
      while (burst != 0 && step_q.size() != 0) begin
        w = step_q.pop_front();
        step_bus.valid <= 1'b1;
        drive_step(w);
        @(posedge clk);
        while (!step_bus.ready) @(posedge clk);
        burst--;
      end
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        step_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    step_bus.valid <= 1'b0;

    // pending is sampled off the active edge to stay clear of the checker
    do @(negedge clk); while (pending != 0);
    repeat (6) @(posedge clk);
    if (fails == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: runs free briefly, then one long hold-off so both pipeline
  // stages fill and the input stalls, then a mix of stall patterns.
  initial begin : sink_pattern
    int span;
    int style;
    status_bus.ready <= 1'b0;
    wait (rst === 1'b0);
    for (int i = 0; i < 30; i++) begin
      @(posedge clk);
      status_bus.ready <= 1'b1;
    end
    for (int i = 0; i < 120; i++) begin
      @(posedge clk);
      status_bus.ready <= 1'b0;
    end
    forever begin
      style = $urandom_range(0, 39);
      span  = (style == 39) ? $urandom_range(80, 150) : $urandom_range(4, 48);
      for (int i = 0; i < span; i++) begin
        @(posedge clk);
        if (style < 12)      status_bus.ready <= 1'b1;
        else if (style < 26) status_bus.ready <= 1'($urandom_range(0, 1));
        else if (style < 33) status_bus.ready <= (i % 3 == 0);
        else                 status_bus.ready <= 1'b0;
      end
    end
  end

  // watchdog: no word moving on either side for too long
  always @(posedge clk) begin
    if (rst || (step_bus.valid && step_bus.ready) ||
        (status_bus.valid && status_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no traffic for %0d cycles", $time, IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> lcd_line_timing_status.f
+incdir+rtl/core
rtl/core/lcd_lts_pkg.sv
rtl/core/lcd_lts_ifs.sv
rtl/core/lcd_lts_step.sv
rtl/core/lcd_line_timing_status.sv
tb/sv/lts_status_checker.sv
tb/sv/tb_top.sv
